>>> hw/rtl/acc_tilt_pkg.sv
`timescale 1ns / 1ps

package acc_tilt_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int PRE_SHIFT     = 32 - SAMPLE_W;
    localparam int SUM_W         = 2 * SAMPLE_W;
    // The root is taken of the sum of squares with 2*PRE_SHIFT extra fraction bits.
    localparam int ROOT_W        = SAMPLE_W + PRE_SHIFT;
    localparam int RAD_W         = 2 * ROOT_W;
    localparam int REM_W         = ROOT_W + 1;
    localparam int CW            = ROOT_W + 4;
    localparam int ZW            = 26;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_CELLS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int STAGE_W       = $clog2(TABLE_LEN);
    localparam int ANGLE_W       = 15;
    localparam int ANGLE_MAX     = 11520;
    localparam int ROUND_BIAS    = 256;
    localparam int ROUND_SHIFT   = 9;
    localparam int FRONT_STAGES  = 2;
    localparam int LATENCY       = FRONT_STAGES + ROOT_W + CORDIC_CELLS + 1;

    typedef enum logic {
        OP_PITCH = 1'b0,
        OP_ROLL  = 1'b1
    } t_op;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] axis;
        logic        [RAD_W-1:0]    rad;
        logic        [ROOT_W-1:0]   root;
        logic        [REM_W-1:0]    rem;
    } t_sqrt_word;

    typedef struct packed {
        logic                 valid;
        logic                 axis_zero;
        logic                 axis_neg;
        logic                 mag_zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic_word;

    // Elementary angles atan(2^-i) in degrees with 16 fraction bits.
    function automatic logic signed [ZW-1:0] atan_step(input logic [STAGE_W-1:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/acc_tilt_front.sv
`timescale 1ns / 1ps

module acc_tilt_front import acc_tilt_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SAMPLE_W-1:0] i_accel_x,
    input  logic signed [SAMPLE_W-1:0] i_accel_y,
    input  logic signed [SAMPLE_W-1:0] i_accel_z,
    input  logic                       i_operation,
    output t_sqrt_word                 o_word
);

    logic signed [SAMPLE_W-1:0] n_axis;
    logic signed [SAMPLE_W-1:0] n_other;
    logic signed [SUM_W-1:0]    n_sq_b;
    logic signed [SUM_W-1:0]    n_sq_c;
    logic        [SUM_W-1:0]    n_sum;

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_axis;
    logic        [SUM_W-1:0]    r_sq_b;
    logic        [SUM_W-1:0]    r_sq_c;
    t_sqrt_word                 r_word;

    always_comb begin
        unique case (t_op'(i_operation))
            OP_PITCH: begin
                n_axis  = i_accel_x;
                n_other = i_accel_y;
            end
            OP_ROLL: begin
                n_axis  = i_accel_y;
                n_other = i_accel_x;
            end
        endcase
    end

    assign n_sq_b = n_other * n_other;
    assign n_sq_c = i_accel_z * i_accel_z;
    // Both squares are at most 2^(2*SAMPLE_W-2), so the sum fits without a carry out.
    assign n_sum  = r_sq_b + r_sq_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_word.valid  <= 1'b0;
        end else begin
            r_valid       <= i_start;
            r_word.valid  <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis      <= n_axis;
        r_sq_b      <= n_sq_b;
        r_sq_c      <= n_sq_c;
        r_word.axis <= r_axis;
        r_word.rad  <= {n_sum, {(RAD_W - SUM_W){1'b0}}};
        r_word.root <= '0;
        r_word.rem  <= '0;
    end

    assign o_word = r_word;

endmodule

>>> hw/rtl/acc_tilt_sqrt_cell.sv
`timescale 1ns / 1ps

module acc_tilt_sqrt_cell import acc_tilt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sqrt_word i_word,
    output t_sqrt_word o_word
);

    logic [REM_W+1:0] n_part;
    logic [REM_W+1:0] n_trial;
    t_sqrt_word       n_word;
    t_sqrt_word       r_word;

    // One root bit per cell: bring down two radicand bits and try a one.
    assign n_part  = {i_word.rem, i_word.rad[RAD_W-1 -: 2]};
    assign n_trial = {1'b0, i_word.root, 2'b01};

    always_comb begin
        n_word       = i_word;
        n_word.rad   = {i_word.rad[RAD_W-3:0], 2'b00};
        if (n_part >= n_trial) begin
            n_word.rem  = REM_W'(n_part - n_trial);
            n_word.root = {i_word.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_word.rem  = n_part[REM_W-1:0];
            n_word.root = {i_word.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word.axis <= n_word.axis;
        r_word.rad  <= n_word.rad;
        r_word.root <= n_word.root;
        r_word.rem  <= n_word.rem;
    end

    assign o_word = r_word;

endmodule

>>> hw/rtl/acc_tilt_cordic_cell.sv
`timescale 1ns / 1ps

module acc_tilt_cordic_cell import acc_tilt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [STAGE_W-1:0] i_stage,
    input  t_cordic_word       i_word,
    output t_cordic_word       o_word
);

    logic signed [CW-1:0] n_dx;
    logic signed [CW-1:0] n_dy;
    logic signed [ZW-1:0] n_step;
    t_cordic_word         n_word;
    t_cordic_word         r_word;

    assign n_dx   = i_word.y >>> i_stage;
    assign n_dy   = i_word.x >>> i_stage;
    assign n_step = atan_step(i_stage);

    // Vectoring mode: rotate towards the x axis and accumulate the angle turned.
    always_comb begin
        n_word = i_word;
        if (!i_word.y[CW-1]) begin
            n_word.x = i_word.x + n_dx;
            n_word.y = i_word.y - n_dy;
            n_word.z = i_word.z + n_step;
        end else begin
            n_word.x = i_word.x - n_dx;
            n_word.y = i_word.y + n_dy;
            n_word.z = i_word.z - n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word.axis_zero <= n_word.axis_zero;
        r_word.axis_neg  <= n_word.axis_neg;
        r_word.mag_zero  <= n_word.mag_zero;
        r_word.x         <= n_word.x;
        r_word.y         <= n_word.y;
        r_word.z         <= n_word.z;
    end

    assign o_word = r_word;

endmodule

>>> hw/rtl/accel_tilt_angle_unit.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; o_busy stays low, the pipeline never stalls.
// Two front stages square and add, 32 root cells give one root bit each,
// 16 CORDIC cells resolve the angle and one stage rounds and saturates.
// Reset is synchronous and active low; it clears every valid bit, so items in flight are lost.
// The receiver cannot stall: each result is shown for exactly one cycle.

module accel_tilt_angle_unit import acc_tilt_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic signed [SAMPLE_W-1:0] i_accel_x,
    input  logic signed [SAMPLE_W-1:0] i_accel_y,
    input  logic signed [SAMPLE_W-1:0] i_accel_z,
    input  logic                       i_operation,
    output logic                       o_done,
    output logic signed [ANGLE_W-1:0]  o_angle
);

    t_sqrt_word           w_sqrt [0:ROOT_W];
    t_cordic_word         w_cordic [0:CORDIC_CELLS];
    logic signed [CW-1:0] n_axis_ext;
    logic signed [ZW:0]   n_biased;
    logic signed [ZW:0]   n_scaled;
    logic signed [ANGLE_W-1:0] n_angle;

    logic                      r_done;
    logic signed [ANGLE_W-1:0] r_angle;

    acc_tilt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_operation (i_operation),
        .o_word      (w_sqrt[0])
    );

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        acc_tilt_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_sqrt[g]),
            .o_word  (w_sqrt[g+1])
        );
    end

    assign n_axis_ext = CW'(w_sqrt[ROOT_W].axis);

    always_comb begin
        w_cordic[0].valid     = w_sqrt[ROOT_W].valid;
        w_cordic[0].axis_zero = (w_sqrt[ROOT_W].axis == '0);
        w_cordic[0].axis_neg  = w_sqrt[ROOT_W].axis[SAMPLE_W-1];
        // The root is zero exactly when the sum of squares is zero.
        w_cordic[0].mag_zero  = (w_sqrt[ROOT_W].root == '0);
        w_cordic[0].x         = {{(CW - ROOT_W){1'b0}}, w_sqrt[ROOT_W].root};
        w_cordic[0].y         = n_axis_ext <<< PRE_SHIFT;
        w_cordic[0].z         = '0;
    end

    for (genvar g = 0; g < CORDIC_CELLS; g++) begin : g_cordic
        acc_tilt_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STAGE_W'(g)),
            .i_word  (w_cordic[g]),
            .o_word  (w_cordic[g+1])
        );
    end

    // Round half up to 1/128 degree, then saturate to plus or minus 90 degrees.
    assign n_biased = (ZW+1)'(w_cordic[CORDIC_CELLS].z) + (ZW+1)'(ROUND_BIAS);
    assign n_scaled = n_biased >>> ROUND_SHIFT;

    always_comb begin
        priority if (w_cordic[CORDIC_CELLS].axis_zero) begin
            n_angle = '0;
        end else if (w_cordic[CORDIC_CELLS].mag_zero) begin
            n_angle = w_cordic[CORDIC_CELLS].axis_neg ? ANGLE_W'(-ANGLE_MAX)
                                                      : ANGLE_W'(ANGLE_MAX);
        end else if (n_scaled > (ZW+1)'(ANGLE_MAX)) begin
            n_angle = ANGLE_W'(ANGLE_MAX);
        end else if (n_scaled < (ZW+1)'(-ANGLE_MAX)) begin
            n_angle = ANGLE_W'(-ANGLE_MAX);
        end else begin
            n_angle = n_scaled[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_cordic[CORDIC_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
    end

    assign o_busy  = 1'b0;
    assign o_done  = r_done;
    assign o_angle = r_angle;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##LATENCY o_done)
        else $error("transaction did not complete after the pipeline latency");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_angle <= ANGLE_W'(ANGLE_MAX)) && (o_angle >= ANGLE_W'(-ANGLE_MAX)))
        else $error("angle outside plus or minus 90 degrees");

    a_zero_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(i_start && (i_accel_x == '0) && (i_operation == OP_PITCH), LATENCY)
        |-> (o_angle == '0))
        else $error("zero pitch axis did not give a zero angle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LATENCY))
        else $error("result strobe without a matching transaction");
`endif

endmodule
